### rtl/triplet_line_dissimilarity_unit_assert.svh
// ---------------------------------------------------------------------------
// triplet line dissimilarity assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef TRIPLET_LINE_DISSIMILARITY_UNIT_ASSERT_SVH
`define TRIPLET_LINE_DISSIMILARITY_UNIT_ASSERT_SVH

// same-cycle implication
`define TLD_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TLD_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tld_pkg.sv
// ---------------------------------------------------------------------------
// tld_pkg
// widths, constants and the queue word of the line dissimilarity unit
// ---------------------------------------------------------------------------
package tld_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int DIR_FRAC_BITS   = 14;

   localparam int COORD_W = 32;
   localparam int DIR_W   = 16;
   localparam int CD_W    = COORD_W + 1;              // center offset
   localparam int ABS_W   = 2 * DIR_FRAC_BITS + 1;    // clamped |cos|
   localparam int ONE     = 1 << (2 * DIR_FRAC_BITS);
   localparam int PERP_LIMIT = (ONE + 99999999) / 100000000;
   localparam int RND     = 1 << (DIR_FRAC_BITS - 1);

   localparam int PROJ_W  = DIR_W + CD_W + 2;         // sum of three products
   localparam int T_W     = PROJ_W - DIR_FRAC_BITS;
   localparam int PR_W    = T_W + DIR_W;
   localparam int R_W     = PR_W - DIR_FRAC_BITS;
   localparam int V_W     = R_W + 1;
   localparam int HALF_W  = V_W / 2;
   localparam int SQ_W    = 2 * V_W + 2;
   localparam int ROOT_W  = SQ_W / 2;
   localparam int TAN_W   = 2 * ABS_W - 1;
   localparam int DIST_SHIFT = 32 - COORD_FRAC_BITS;
   localparam int QUO_W   = ROOT_W + DIST_SHIFT;

   localparam int SCALE_W = 32;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd65536;

   localparam int RES_W = 48;
   localparam logic [RES_W-1:0] SAT48       = {RES_W{1'b1}};
   localparam logic [RES_W-1:0] PERP_RESULT = 48'd6553600000000;

   localparam int QDEPTH = 4;

   typedef struct packed {
      logic [2:0][CD_W-1:0]  d12;
      logic [2:0][DIR_W-1:0] u;
      logic [2:0][DIR_W-1:0] w;
      logic [ABS_W-1:0]      absc;
      logic                  perp;
   } tld_entry_type;

endpackage

### rtl/triplet_line_dissimilarity_unit.sv
// ---------------------------------------------------------------------------
// triplet_line_dissimilarity_unit
// dissimilarity of two line segments from distance and direction angle
// ---------------------------------------------------------------------------
// channel  | dir | handshake             | payload
// req      | in  | req_tvalid/req_tready | two centers and two directions
// rsp      | out | rsp_tvalid/rsp_tready | dissimilarity, perpendicular flag
// csr      | in  | csr_wr_en             | distance_scale
//
// one word per cycle sustained while the response side is ready; a request
// word passes the queue write, 6 arithmetic, 41 root and 57 divider stages
// and the result register (the front register loads on the request edge)
// synchronous reset clears front, queue and pipeline valids, scale -> 1.0
// a stalled response freezes the back pipeline, the queue (4 words by
// default) keeps the front accepting until it fills
// ---------------------------------------------------------------------------
module triplet_line_dissimilarity_unit
   import tld_pkg::*;
#(
   parameter int QUEUE_DEPTH = QDEPTH
)
(
   input  logic               clock,
   input  logic               reset,
   // request: first_center_x/y/z, first_dir_x/y/z,
   //          second_center_x/y/z, second_dir_x/y/z (low bit up)
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [287:0]       req_tdata,
   // response: dissimilarity
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RES_W-1:0]   rsp_tdata,
   // response: perpendicular_flag
   output logic               rsp_tuser,
   // distance_scale register
   input  logic               csr_wr_en,
   input  logic [SCALE_W-1:0] csr_wr_data
);

   logic [SCALE_W-1:0] scale_ff;

   // front to queue
   logic          q_full;
   logic          push;
   tld_entry_type push_entry;

   // queue to back
   logic          pop;
   logic          q_nonempty;
   tld_entry_type head;

   // distance scale; the user must write it only while idle, the block itself does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   tld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   tld_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .nonempty   (q_nonempty),
      .head       (head)
   );

   tld_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_nonempty (q_nonempty),
      .pop        (pop),
      .scale      (scale_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/tld_front.sv
// ---------------------------------------------------------------------------
// tld_front
// takes input words, forms center offsets and cosine, flags perpendicular
// ---------------------------------------------------------------------------
module tld_front
   import tld_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [287:0]  req_tdata,
   input  logic          q_full,
   output logic          push,
   output tld_entry_type push_entry
);

   logic          vld_ff;
   tld_entry_type entry_ff;
   tld_entry_type entry_in;
   logic          adv;

   assign adv        = !vld_ff || !q_full;
   assign req_tready = adv;
   assign push       = vld_ff && !q_full;
   assign push_entry = entry_ff;

   always_comb begin
      logic signed [COORD_W-1:0] c1;
      logic signed [COORD_W-1:0] c2;
      logic signed [CD_W-1:0]    diff;
      logic signed [COORD_W-1:0] uw;
      logic signed [33:0]        cosv;
      logic [33:0]               mag;
      cosv     = '0;
      entry_in = '0;
      for (int i = 0; i < 3; i++) begin
         c1   = $signed(req_tdata[i*COORD_W +: COORD_W]);
         c2   = $signed(req_tdata[144 + i*COORD_W +: COORD_W]);
         diff = CD_W'(c2) - CD_W'(c1);
         entry_in.d12[i] = diff;
         entry_in.u[i]   = req_tdata[96 + i*DIR_W +: DIR_W];
         entry_in.w[i]   = req_tdata[240 + i*DIR_W +: DIR_W];
         uw   = COORD_W'($signed(req_tdata[96 + i*DIR_W +: DIR_W]))
              * COORD_W'($signed(req_tdata[240 + i*DIR_W +: DIR_W]));
         cosv = cosv + 34'(uw);
      end
      mag = cosv[33] ? 34'(-cosv) : 34'(cosv);
      if (mag > 34'(ONE)) begin
         entry_in.absc = ABS_W'(ONE);
      end else begin
         entry_in.absc = mag[ABS_W-1:0];
      end
      entry_in.perp = entry_in.absc < ABS_W'(PERP_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         entry_ff <= entry_in;
      end
   end

endmodule

### rtl/tld_queue.sv
// ---------------------------------------------------------------------------
// tld_queue
// short fifo between front and back
// ---------------------------------------------------------------------------
module tld_queue
   import tld_pkg::*;
#(
   parameter int DEPTH = QDEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  tld_entry_type push_entry,
   input  logic          pop,
   output logic          full,
   output logic          nonempty,
   output tld_entry_type head
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   tld_entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_pop;

   assign full     = cnt_ff == CW'(DEPTH);
   assign nonempty = cnt_ff != '0;
   assign head     = mem_ff[rd_ff];
   assign do_pop   = pop && nonempty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

### rtl/tld_root.sv
// ---------------------------------------------------------------------------
// tld_root
// pipelined integer square root, one result bit per stage
// ---------------------------------------------------------------------------
module tld_root
   import tld_pkg::*;
#(
   parameter int RAD_W = SQ_W
)
(
   input  logic               clock,
   input  logic               en,
   input  logic [RAD_W-1:0]   rad,
   output logic [RAD_W/2-1:0] root
);

   localparam int RW = RAD_W / 2;

   logic [RW+1:0]    rem_ff  [1:RW];
   logic [RW-1:0]    root_ff [1:RW];
   logic [RAD_W-1:0] rad_ff  [1:RW];

   for (genvar s = 0; s < RW; s++) begin : g_stage
      logic [RW+1:0]    rem_cur;
      logic [RW-1:0]    root_cur;
      logic [RAD_W-1:0] rad_cur;
      logic [RW+1:0]    rs;
      logic [RW+1:0]    trial;
      logic             ge;

      if (s == 0) begin : g_first
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign rad_cur  = rad;
      end else begin : g_next
         assign rem_cur  = rem_ff[s];
         assign root_cur = root_ff[s];
         assign rad_cur  = rad_ff[s];
      end

      assign rs    = {rem_cur[RW-1:0], rad_cur[RAD_W-1 -: 2]};
      assign trial = {root_cur, 2'b01};
      assign ge    = rs >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1]  <= ge ? rs - trial : rs;
            root_ff[s+1] <= {root_cur[RW-2:0], ge};
            rad_ff[s+1]  <= {rad_cur[RAD_W-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[RW];

endmodule

### rtl/tld_div.sv
// ---------------------------------------------------------------------------
// tld_div
// pipelined restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
module tld_div
   import tld_pkg::*;
#(
   parameter int NUM_W = QUO_W,
   parameter int DEN_W = SCALE_W
)
(
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ff [1:NUM_W];
   logic [DEN_W-1:0] den_ff [1:NUM_W];
   logic [NUM_W-1:0] num_ff [1:NUM_W];
   logic [NUM_W-1:0] quo_ff [1:NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [DEN_W-1:0] rem_cur;
      logic [DEN_W-1:0] den_cur;
      logic [NUM_W-1:0] num_cur;
      logic [NUM_W-1:0] quo_cur;
      logic [DEN_W:0]   rs;
      logic [DEN_W:0]   diff;
      logic             ge;

      if (s == 0) begin : g_first
         assign rem_cur = '0;
         assign den_cur = den;
         assign num_cur = num;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[s];
         assign den_cur = den_ff[s];
         assign num_cur = num_ff[s];
         assign quo_cur = quo_ff[s];
      end

      assign rs   = {rem_cur, num_cur[NUM_W-1]};
      assign ge   = rs >= {1'b0, den_cur};
      assign diff = rs - {1'b0, den_cur};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= ge ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
            den_ff[s+1] <= den_cur;
            num_ff[s+1] <= {num_cur[NUM_W-2:0], 1'b0};
            quo_ff[s+1] <= {quo_cur[NUM_W-2:0], ge};
         end
      end
   end

   assign quo = quo_ff[NUM_W];

endmodule

### rtl/tld_back.sv
// ---------------------------------------------------------------------------
// tld_back
// perpendicular distances, roots, divisions and the result register
// ---------------------------------------------------------------------------
module tld_back
   import tld_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  tld_entry_type      head,
   input  logic               q_nonempty,
   output logic               pop,
   input  logic [SCALE_W-1:0] scale,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RES_W-1:0]   rsp_tdata,
   output logic               rsp_tuser
);

   localparam int ROOT_OUT = 6 + ROOT_W;
   localparam int LAT      = ROOT_OUT + QUO_W + 1;

   logic en;
   logic [LAT:1]     vld_ff;
   logic [LAT:1]     perp_ff;
   logic [ABS_W-1:0] absc_ff [1:ROOT_OUT];

   // stage registers
   logic [1:0][PROJ_W-1:0]     p1_ff;
   logic [2:0][CD_W-1:0]       d1_ff, d2_ff;
   logic [2:0][DIR_W-1:0]      u1_ff, w1_ff;
   logic [TAN_W-1:0]           tan1_ff, tan2_ff, tan3_ff, tan4_ff, tan5_ff, tan6_ff;
   logic [1:0][2:0][PR_W-1:0]  pr2_ff;
   logic [1:0][2:0][V_W-1:0]   m3_ff;
   logic [1:0][2:0][2:0][2*HALF_W-1:0] pp4_ff;
   logic [1:0][SQ_W-1:0]       s5_ff;
   logic [SQ_W-1:0]            big6_ff;
   logic [RES_W-1:0]           out_data_ff;

   logic [1:0][PROJ_W-1:0]     p1_in;
   logic [TAN_W-1:0]           tan1_in;
   logic [1:0][2:0][PR_W-1:0]  pr2_in;
   logic [1:0][2:0][V_W-1:0]   m3_in;
   logic [1:0][2:0][2:0][2*HALF_W-1:0] pp4_in;
   logic [1:0][SQ_W-1:0]       s5_in;
   logic [RES_W-1:0]           out_data_in;

   logic [ROOT_W-1:0] dist_root, tan_root;
   logic [QUO_W-1:0]  dist_quo, tan_quo;

   assign en  = !vld_ff[LAT] || rsp_tready;
   assign pop = en && q_nonempty;

   // projections onto each own direction, tangent radicand
   always_comb begin
      logic signed [PROJ_W-2:0] ma;
      logic signed [PROJ_W-2:0] mb;
      logic signed [CD_W-1:0]   nd;
      logic signed [PROJ_W-1:0] sa;
      logic signed [PROJ_W-1:0] sb;
      logic [ABS_W-1:0]         om;
      logic [ABS_W:0]           op;
      sa = '0;
      sb = '0;
      for (int i = 0; i < 3; i++) begin
         nd = -$signed(head.d12[i]);
         ma = (PROJ_W-1)'($signed(head.u[i])) * (PROJ_W-1)'($signed(head.d12[i]));
         mb = (PROJ_W-1)'($signed(head.w[i])) * (PROJ_W-1)'(nd);
         sa = sa + PROJ_W'(ma);
         sb = sb + PROJ_W'(mb);
      end
      p1_in[0] = sa;
      p1_in[1] = sb;
      om = ABS_W'(ONE) - head.absc;
      op = (ABS_W+1)'(ONE) + {1'b0, head.absc};
      tan1_in = TAN_W'(om) * TAN_W'(op);
   end

   // round projection, scale each direction component
   always_comb begin
      logic signed [PROJ_W-1:0] tmp;
      logic signed [T_W-1:0]    t;
      logic signed [PR_W-1:0]   pr;
      for (int k = 0; k < 2; k++) begin
         tmp = $signed(p1_ff[k]) + PROJ_W'(RND);
         t   = tmp[PROJ_W-1:DIR_FRAC_BITS];
         for (int i = 0; i < 3; i++) begin
            if (k == 0) begin
               pr = PR_W'(t) * PR_W'($signed(u1_ff[i]));
            end else begin
               pr = PR_W'(t) * PR_W'($signed(w1_ff[i]));
            end
            pr2_in[k][i] = pr;
         end
      end
   end

   // perpendicular residual magnitudes
   always_comb begin
      logic signed [PR_W-1:0] tmp;
      logic signed [V_W-1:0]  r;
      logic signed [V_W-1:0]  de;
      logic signed [V_W-1:0]  v;
      for (int k = 0; k < 2; k++) begin
         for (int i = 0; i < 3; i++) begin
            tmp = $signed(pr2_ff[k][i]) + PR_W'(RND);
            r   = V_W'($signed(tmp[PR_W-1:DIR_FRAC_BITS]));
            de  = V_W'($signed(d2_ff[i]));
            if (k == 1) begin
               de = -de;
            end
            v = de - r;
            m3_in[k][i] = v[V_W-1] ? V_W'(-v) : V_W'(v);
         end
      end
   end

   // partial products of the squares
   always_comb begin
      logic [HALF_W-1:0] mh;
      logic [HALF_W-1:0] ml;
      for (int k = 0; k < 2; k++) begin
         for (int i = 0; i < 3; i++) begin
            mh = m3_ff[k][i][V_W-1:HALF_W];
            ml = m3_ff[k][i][HALF_W-1:0];
            pp4_in[k][i][0] = (2*HALF_W)'(mh) * (2*HALF_W)'(mh);
            pp4_in[k][i][1] = (2*HALF_W)'(mh) * (2*HALF_W)'(ml);
            pp4_in[k][i][2] = (2*HALF_W)'(ml) * (2*HALF_W)'(ml);
         end
      end
   end

   // squared norms
   always_comb begin
      logic [SQ_W-1:0] acc;
      for (int k = 0; k < 2; k++) begin
         acc = '0;
         for (int i = 0; i < 3; i++) begin
            acc = acc + (SQ_W'(pp4_ff[k][i][0]) << (2 * HALF_W))
                      + (SQ_W'(pp4_ff[k][i][1]) << (HALF_W + 1))
                      + SQ_W'(pp4_ff[k][i][2]);
         end
         s5_in[k] = acc;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff   <= p1_in;
         d1_ff   <= head.d12;
         u1_ff   <= head.u;
         w1_ff   <= head.w;
         tan1_ff <= tan1_in;
         pr2_ff  <= pr2_in;
         d2_ff   <= d1_ff;
         tan2_ff <= tan1_ff;
         m3_ff   <= m3_in;
         tan3_ff <= tan2_ff;
         pp4_ff  <= pp4_in;
         tan4_ff <= tan3_ff;
         s5_ff   <= s5_in;
         tan5_ff <= tan4_ff;
         big6_ff <= (s5_ff[0] <= s5_ff[1]) ? s5_ff[1] : s5_ff[0];
         tan6_ff <= tan5_ff;
         perp_ff <= {perp_ff[LAT-1:1], head.perp};
         absc_ff[1] <= head.absc;
         for (int j = 2; j <= ROOT_OUT; j++) begin
            absc_ff[j] <= absc_ff[j-1];
         end
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-1:1], pop};
      end
   end

   tld_root #(.RAD_W(SQ_W)) u_root_dist (
      .clock (clock),
      .en    (en),
      .rad   (big6_ff),
      .root  (dist_root)
   );

   tld_root #(.RAD_W(SQ_W)) u_root_tan (
      .clock (clock),
      .en    (en),
      .rad   (SQ_W'(tan6_ff)),
      .root  (tan_root)
   );

   tld_div #(.NUM_W(QUO_W), .DEN_W(SCALE_W)) u_div_dist (
      .clock (clock),
      .en    (en),
      .num   ({dist_root, {DIST_SHIFT{1'b0}}}),
      .den   (scale),
      .quo   (dist_quo)
   );

   tld_div #(.NUM_W(QUO_W), .DEN_W(SCALE_W)) u_div_tan (
      .clock (clock),
      .en    (en),
      .num   ({tan_root, {DIST_SHIFT{1'b0}}}),
      .den   (SCALE_W'(absc_ff[ROOT_OUT])),
      .quo   (tan_quo)
   );

   // saturate terms and sum, fixed value when perpendicular
   always_comb begin
      logic [RES_W-1:0] dterm;
      logic [RES_W-1:0] tterm;
      logic [RES_W:0]   sum;
      dterm = (|dist_quo[QUO_W-1:RES_W]) ? SAT48 : dist_quo[RES_W-1:0];
      tterm = (|tan_quo[QUO_W-1:RES_W])  ? SAT48 : tan_quo[RES_W-1:0];
      sum   = {1'b0, dterm} + {1'b0, tterm};
      if (perp_ff[LAT-1]) begin
         out_data_in = PERP_RESULT;
      end else if (sum[RES_W]) begin
         out_data_in = SAT48;
      end else begin
         out_data_in = sum[RES_W-1:0];
      end
   end

   assign rsp_tvalid = vld_ff[LAT];
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = perp_ff[LAT];

endmodule

### rtl/tld_checker.sv
// ---------------------------------------------------------------------------
// tld_checker
// port-level checks of the line dissimilarity unit
// ---------------------------------------------------------------------------
`include "triplet_line_dissimilarity_unit_assert.svh"

module tld_checker
   import tld_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RES_W-1:0] rsp_tdata,
   input logic             rsp_tuser
);

   // stalled response word holds
   `TLD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response word changed while stalled")

   // perpendicular flag carries the fixed value
   `TLD_ASSERT_NOW(a_perp_value, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == PERP_RESULT, "perpendicular word without fixed value")

   // no response word right after reset
   `TLD_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid, "response word after reset")

endmodule

bind triplet_line_dissimilarity_unit tld_checker u_tld_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// stream testbench for the line dissimilarity unit: a queue-fed driver, a
// stalling receiver and a bit-exact predictor of the dissimilarity word
// ---------------------------------------------------------------------------
module tb_top
   import tld_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 400;
   localparam int DRAIN_WAIT  = 120;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   // c1 x/y/z, u x/y/z, c2 x/y/z, w x/y/z (low bit up)
   logic [287:0]       req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   // dissimilarity
   logic [RES_W-1:0]   rsp_tdata;
   // perpendicular_flag
   logic               rsp_tuser;
   logic               csr_wr_en;
   logic [SCALE_W-1:0] csr_wr_data;

   typedef struct {
      logic [RES_W-1:0] dissim;
      logic             perp_flag;
   } line_result_type;

   logic [287:0]     pair_pending[$];     // words waiting for the driver
   line_result_type  result_expected[$];  // predicted words in arrival order
   logic [31:0]      scale_shadow;        // our copy of distance_scale
   int               fail_count;
   int               cycle_count;
   bit               word_taken;          // set at the edge the driver's word is accepted
   bit               no_idle;             // last part of the run runs flat out
   bit               hold_request;        // asks the receiver for one long stall
   int               send_gap, recv_gap, hold_left;
   bit               send_quiet, recv_quiet;

   triplet_line_dissimilarity_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // integer square root, floor
   function automatic logic [63:0] isqrt128(logic [127:0] n);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      return r;
   endfunction

   // floor(s * 2^16 / d), saturating at 48 bits, zero divisor saturates
   function automatic logic [RES_W-1:0] fixed_div16(logic [63:0] s, logic [63:0] d);
      logic [127:0] q;
      if (d == 0) return SAT48;
      q = ({64'd0, s} << 16) / {64'd0, d};
      if (q > {80'd0, SAT48}) return SAT48;
      return q[RES_W-1:0];
   endfunction

   // squared perpendicular distance of offset d from the line along dir
   function automatic logic [127:0] perp_dist_sq(longint d[3], longint dir[3]);
      longint proj, along, v;
      logic [63:0] m;
      logic [127:0] acc;
      proj = 0;
      acc = '0;
      for (int i = 0; i < 3; i++) proj += dir[i] * d[i];
      along = (proj + RND) >>> DIR_FRAC_BITS;
      for (int i = 0; i < 3; i++) begin
         v = d[i] - ((along * dir[i] + RND) >>> DIR_FRAC_BITS);
         m = v < 0 ? 64'(-v) : 64'(v);
         acc += {64'd0, m} * {64'd0, m};
      end
      return acc;
   endfunction

   function automatic line_result_type predict_dissimilarity(logic [287:0] pair,
                                                             logic [31:0] scale);
      longint c1[3], c2[3], u[3], w[3], d12[3], d21[3];
      longint cosv;
      logic [63:0] one, absc, dist_len, root;
      logic [127:0] pa, pb;
      logic [RES_W-1:0] dterm, tterm;
      logic [RES_W:0] total;
      line_result_type res;
      cosv = 0;
      for (int i = 0; i < 3; i++) begin
         c1[i]  = longint'($signed(pair[32*i +: 32]));
         u[i]   = longint'($signed(pair[96 + 16*i +: 16]));
         c2[i]  = longint'($signed(pair[144 + 32*i +: 32]));
         w[i]   = longint'($signed(pair[240 + 16*i +: 16]));
         d12[i] = c2[i] - c1[i];
         d21[i] = c1[i] - c2[i];
         cosv  += u[i] * w[i];
      end
      one  = 64'd1 << (2 * DIR_FRAC_BITS);
      absc = cosv < 0 ? 64'(-cosv) : 64'(cosv);
      if (absc > one) absc = one;
      // near perpendicular directions give the fixed large result
      if (absc < 64'(PERP_LIMIT)) begin
         res.dissim    = PERP_RESULT;
         res.perp_flag = 1'b1;
         return res;
      end
      pa       = perp_dist_sq(d12, u);
      pb       = perp_dist_sq(d21, w);
      dist_len = isqrt128(pa <= pb ? pb : pa);
      dterm    = fixed_div16(dist_len, {32'd0, scale});
      root     = isqrt128({64'd0, one - absc} * {64'd0, one + absc});
      tterm    = fixed_div16(root, absc);
      total    = {1'b0, dterm} + {1'b0, tterm};
      res.dissim    = total[RES_W] ? SAT48 : total[RES_W-1:0];
      res.perp_flag = 1'b0;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic logic [287:0] pack_pair(logic [2:0][31:0] c1, logic [2:0][15:0] u,
                                              logic [2:0][31:0] c2, logic [2:0][15:0] w);
      return {w, c2, u, c1};
   endfunction

   // append one word to the driver queue
   function automatic void add_pair(logic [287:0] pair);
      pair_pending.insert(pair_pending.size(), pair);
   endfunction

   function automatic logic [31:0] rand_coord();
      int sh;
      if ($urandom_range(0, 3) == 0) return $urandom;
      sh = $urandom_range(4, 26);
      return 32'(int'($urandom_range(0, (1 << sh) - 1)) - (1 << (sh - 1)));
   endfunction

   function automatic logic [15:0] rand_dir();
      return 16'(int'($urandom_range(0, 32768)) - 16384);
   endfunction

   function automatic logic [287:0] random_pair();
      logic [2:0][31:0] c1, c2;
      logic [2:0][15:0] u, w;
      int kind;
      for (int i = 0; i < 3; i++) begin
         c1[i] = rand_coord();
         c2[i] = rand_coord();
         u[i]  = rand_dir();
         w[i]  = rand_dir();
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         // exactly perpendicular: rotate u by 90 degrees in the xy plane
         w[0] = -u[1];
         w[1] = u[0];
         w[2] = '0;
      end else if (kind == 1) begin
         // nearly parallel or antiparallel
         for (int i = 0; i < 3; i++)
            w[i] = ($urandom_range(0, 1) ? u[i] : -u[i]) + 16'($urandom_range(0, 2)) - 16'd1;
         for (int i = 0; i < 3; i++)
            if ($signed(w[i]) > 16384 || $signed(w[i]) < -16384) w[i] = u[i];
      end else if (kind == 2) begin
         // close centers so the distance term stays small
         for (int i = 0; i < 3; i++) c2[i] = c1[i] + 32'($urandom_range(0, 4095)) - 32'd2048;
      end
      return pack_pair(c1, u, c2, w);
   endfunction

   task automatic queue_random(int count);
      for (int k = 0; k < count; k++) add_pair(random_pair());
   endtask

   // wait for every word to drain, then leave the pipeline a latency's worth
   task automatic wait_idle();
      while (pair_pending.size() != 0 || result_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_scale(logic [31:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      scale_shadow  = value;
   endtask

   task automatic queue_directed();
      logic [2:0][31:0] zc, maxc, minc;
      logic [2:0][15:0] ex, ey, nx, big, odd;
      zc   = '0;
      maxc = {3{32'h7FFF_FFFF}};
      minc = {3{32'h8000_0000}};
      ex   = {16'd0, 16'd0, 16'd16384};
      ey   = {16'd0, 16'd16384, 16'd0};
      nx   = {16'd0, 16'd0, -16'd16384};
      big  = {3{16'd16384}};
      odd  = {3{-16'd16384}};
      add_pair(pack_pair(zc, ex, zc, ex));       // identical lines
      add_pair(pack_pair(maxc, ex, minc, ex));   // extreme centers, parallel
      add_pair(pack_pair(minc, odd, maxc, big)); // extreme both ways
      add_pair(pack_pair(zc, ex, maxc, ey));     // perpendicular
      add_pair(pack_pair(minc, ex, zc, nx));     // antiparallel
      add_pair(pack_pair(zc, big, zc, big));     // cosine above one, clamped
      add_pair(pack_pair(maxc, big, minc, odd)); // clamped at minus one
      // cosine of 3 / 2^28, just past the perpendicular limit
      add_pair(pack_pair(zc, {16'd0, 16'd0, 16'd3}, maxc,
                         {16'd0, 16'd16384, 16'd1}));
      // cosine of 2 / 2^28, inside the perpendicular limit
      add_pair(pack_pair(zc, {16'd0, 16'd0, 16'd2}, maxc,
                         {16'd0, 16'd16384, 16'd1}));
      add_pair(pack_pair(zc, '0, maxc, ex));     // zero direction
      add_pair(pack_pair({32'd0, 32'd0, 32'd65536}, ey, zc, ey));
      add_pair(pack_pair(zc, {16'd11585, 16'd11585, 16'd0}, minc, ex));
   endtask

   // ---------------------------------------------------------------------
   // request driver: changes at the falling edge, holds until accepted
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!(req_tvalid && !word_taken)) begin
         word_taken = 1'b0;
         if ($urandom_range(0, 199) == 0) send_quiet = !send_quiet;
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (!no_idle && !send_quiet && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 12) - 1;
            req_tvalid <= 1'b0;
         end else if (pair_pending.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pair_pending[0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // response side ready: random bursts plus one long hold on request
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if ($urandom_range(0, 199) == 0) recv_quiet = !recv_quiet;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (!no_idle && !recv_quiet && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(1, 12) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // rising edge: accepted request words get predicted, responses checked
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      line_result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready) begin
            result_expected.insert(result_expected.size(),
                                   predict_dissimilarity(req_tdata, scale_shadow));
            void'(pair_pending.pop_front());
            word_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (result_expected.size() == 0) begin
               $error("response word with nothing expected: dissimilarity %0d flag %0d",
                      rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = result_expected.pop_front();
               if (rsp_tdata !== want.dissim) begin
                  $error("dissimilarity: expected %0d, got %0d", want.dissim, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== want.perp_flag) begin
                  $error("perpendicular_flag: expected %0d, got %0d",
                         want.perp_flag, rsp_tuser);
                  fail_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // test sequence: one phase per scale setting
   // ---------------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      scale_shadow = SCALE_RESET;
      fail_count   = 0;
      cycle_count  = 0;
      word_taken   = 1'b0;
      no_idle      = 1'b0;
      hold_request = 1'b0;
      send_gap     = 0;
      recv_gap     = 0;
      hold_left    = 0;
      send_quiet   = 1'b0;
      recv_quiet   = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // reset scale of 1.0, directed words first
      queue_directed();
      queue_random(300);
      // receiver stalls long while the driver keeps offering, queue backs up
      hold_request = 1'b1;
      wait_idle();

      // smallest nonzero scale: distance term saturates easily
      write_scale(32'd1);
      queue_directed();
      queue_random(300);
      wait_idle();

      // largest scale: distance term nearly vanishes
      write_scale(32'hFFFF_FFFF);
      queue_random(300);
      wait_idle();

      // zero scale saturates unless perpendicular
      write_scale(32'd0);
      queue_random(100);
      wait_idle();

      write_scale($urandom_range(1, 32'h0010_0000));
      queue_random(300);
      wait_idle();

      // final stretch with no idling on either side
      write_scale(32'd65536);
      no_idle = 1'b1;
      queue_random(300);
      wait_idle();

      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
